// ===== sv/kcm_pkg.sv =====
// Package for the Kuznyechik CMAC block: S-box, linear-layer helpers, command type.
// No dependencies.
package kcm_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned RkIdxW    = 4;
   localparam logic [7:0]  GfPoly    = 8'hC3;
   localparam logic [7:0]  SubkeyPoly = 8'h87;

   typedef struct packed {
      logic        load_block;   // load chain ^ block (^ subkey) into state
      logic        load_chain;   // load chain (^ subkey); block already folded in
      logic        load_zero;    // clear state for R = E(0)
      logic        absorb;       // fold the transferred block into the chain
      logic        last;         // final block of message
      logic        full;         // final block complete
      logic        round;        // apply one LSX round with current key
      logic        final_xor;    // apply last round key
      logic [RkIdxW-1:0] rk_idx; // round key read address
      logic        ks_init;      // load key registers into key schedule
      logic        ks_step;      // one Feistel step of key schedule
      logic [5:0]  ks_const;     // constant index 1..32
      logic        ks_store;     // write one schedule half into the round keys
      logic        ks_sel;       // 0: odd half (ka), 1: even half (kb)
      logic [RkIdxW-1:0] ks_slot; // round key write address
      logic        save_zero;    // state holds R
      logic        save_chain;   // state holds chain value
      logic        clear_chain;
      logic        save_tag;     // state holds the tag
   } kcm_cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
       252,238,221, 17,207,110, 49, 22,251,196,250,218, 35,197,  4, 77,
       233,119,240,219,147, 46,153,186, 23, 54,241,187, 20,205, 95,193,
       249, 24,101, 90,226, 92,239, 33,129, 28, 60, 66,139,  1,142, 79,
         5,132,  2,174,227,106,143,160,  6, 11,237,152,127,212,211, 31,
       235, 52, 44, 81,234,200, 72,171,242, 42,104,162,253, 58,206,204,
       181,112, 14, 86,  8, 12,118, 18,191,114, 19, 71,156,183, 93,135,
        21,161,150, 41, 16,123,154,199,243,145,120,111,157,158,178,177,
        50,117, 25, 61,255, 53,138,126,109, 84,198,128,195,189, 13, 87,
       223,245, 36,169, 62,168, 67,201,215,121,214,246,124, 34,185,  3,
       224, 15,236,222,122,148,176,188,220,232, 40, 80, 78, 51, 10, 74,
       167,151, 96,115, 30,  0, 98, 68, 26,184, 56,130,100,159, 38, 65,
       173, 69, 70,146, 39, 94, 85, 47,140,163,165,125,105,213,149, 59,
         7, 88,179, 64,134,172, 29,247, 48, 55,107,228,136,217,231,137,
       225, 27,131, 73, 76, 63,248,254,141, 83,170,144,202,216,133, 97,
        32,113,103,164, 45, 43,  9, 91,203,155, 37,208,190,229,108, 82,
        89,166,116,210,230,244,180,192,209,102,175,194, 57, 75, 99,182};
      return t[x];
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] aa;
      p  = '0;
      aa = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ aa;
         aa = aa[7] ? ({aa[6:0], 1'b0} ^ GfPoly) : {aa[6:0], 1'b0};
      end
      return p;
   endfunction

   function automatic logic [7:0] lin_coef(input int unsigned i);
      logic [7:0] c [16];
      c = '{148, 32,133, 16,194,192,  1,251,  1,192,194, 16,133, 32,148,  1};
      return c[i];
   endfunction

   // One R step of the linear layer; byte 0 is bits [127:120].
   function automatic logic [127:0] r_step(input logic [127:0] v);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(v[127-8*i -: 8], lin_coef(i));
      return {acc, v[127:8]};
   endfunction

   function automatic logic [127:0] s_layer(input logic [127:0] v);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) o[8*i +: 8] = sbox(v[8*i +: 8]);
      return o;
   endfunction

   function automatic logic [127:0] subkey_double(input logic [127:0] v);
      logic [127:0] o;
      o = {v[126:0], 1'b0};
      if (v[127]) o[7:0] = o[7:0] ^ SubkeyPoly;
      return o;
   endfunction

endpackage

// ===== sv/kcm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module kcm_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== sv/kcm_datapath.sv =====
// Datapath: cipher state, chain, subkey source, key schedule, round-key RAM and tag register.
// Depends on kcm_pkg and kcm_ram.
module kcm_datapath import kcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  kcm_cmd_type       cmd,
   input  logic [255:0]      key,
   input  logic [127:0]      block,
   output logic [63:0]       tag
);
   logic [127:0] state_ff, state_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] zero_ff, zero_in;
   logic [127:0] ka_ff, ka_in, kb_ff, kb_in;
   logic [127:0] rk_wdata, rk_rdata;
   logic [127:0] lin_st, lin_c, subkey, pad_key, x;
   logic [63:0]  tag_ff, tag_in;

   kcm_ram #(.Width(128), .Depth(NumRounds)) u_rk (
      .clock  (clock),
      .wr_en  (cmd.ks_store),
      .wr_addr(cmd.ks_slot),
      .wr_data(rk_wdata),
      .rd_addr(cmd.rk_idx),
      .rd_data(rk_rdata)
   );

   // each schedule pair goes out as ka (odd key) then kb (even key)
   assign rk_wdata = cmd.ks_sel ? kb_ff : ka_ff;

   always_comb begin
      lin_st = s_layer(state_ff ^ rk_rdata);
      for (int i = 0; i < 16; i++) lin_st = r_step(lin_st);
      lin_c = {122'd0, cmd.ks_const};
      for (int i = 0; i < 16; i++) lin_c = r_step(lin_c);
      x = s_layer(ka_ff ^ lin_c);
      for (int i = 0; i < 16; i++) x = r_step(x);
   end

   always_comb begin
      subkey = subkey_double(zero_ff);
      if (!cmd.full) subkey = subkey_double(subkey);
      pad_key  = cmd.last ? subkey : 128'd0;
      state_in = state_ff;
      chain_in = chain_ff;
      zero_in  = zero_ff;
      ka_in    = ka_ff;
      kb_in    = kb_ff;
      tag_in   = tag_ff;
      if (cmd.load_block) state_in = chain_ff ^ block ^ pad_key;
      else if (cmd.load_chain) state_in = chain_ff ^ pad_key;
      else if (cmd.load_zero) state_in = '0;
      else if (cmd.round) state_in = lin_st;
      else if (cmd.final_xor) state_in = state_ff ^ rk_rdata;
      if (cmd.save_zero) zero_in = state_ff;
      if (cmd.save_tag) tag_in = state_ff[127:64];
      if (cmd.clear_chain) chain_in = '0;
      else if (cmd.save_chain) chain_in = state_ff;
      else if (cmd.absorb) chain_in = chain_ff ^ block;
      if (cmd.ks_init) begin
         ka_in = key[255:128];
         kb_in = key[127:0];
      end else if (cmd.ks_step) begin
         ka_in = x ^ kb_ff;
         kb_in = ka_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
      state_ff <= state_in;
      zero_ff  <= zero_in;
      ka_ff    <= ka_in;
      kb_ff    <= kb_in;
      tag_ff   <= tag_in;
   end

   assign tag = tag_ff;
endmodule

// ===== sv/kcm_ctrl.sv =====
// Controller: key expansion, R = E(0), per-block round sequencing, result handshake.
// Depends on kcm_pkg.
module kcm_ctrl import kcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        key_write,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_last,
   input  logic        req_full,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output kcm_cmd_type cmd,
   output logic        busy
);
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StKsPutA = 3'd1;
   localparam logic [2:0] StKsPutB = 3'd2;
   localparam logic [2:0] StKsRun  = 3'd3;
   localparam logic [2:0] StLoad   = 3'd4;
   localparam logic [2:0] StRound  = 3'd5;
   localparam logic [2:0] StFinal  = 3'd6;
   localparam logic [2:0] StDone   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] grp_ff, grp_in;
   logic       ready_ff, ready_in;
   logic       zero_ff, zero_in;   // running E(0)
   logic       last_ff, last_in;
   logic       full_ff, full_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign busy      = state_ff != StIdle;
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      grp_in   = grp_ff;
      ready_in = ready_ff;
      zero_in  = zero_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.full = full_ff;
      cmd.last = last_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               last_in = req_last;
               full_in = req_full;
               cnt_in  = 4'd0;
               if (!ready_ff) begin
                  // hold the block in the chain while the schedule runs
                  cmd.absorb  = 1'b1;
                  cmd.ks_init = 1'b1;
                  grp_in = 3'd0;
                  state_in = StKsPutA;
               end else begin
                  cmd.load_block = 1'b1;
                  cmd.last = req_last;
                  cmd.full = req_full;
                  state_in = StRound;
               end
            end
         end
         StKsPutA: begin
            cmd.ks_store = 1'b1;
            cmd.ks_slot  = {grp_ff, 1'b0};
            state_in = StKsPutB;
         end
         StKsPutB: begin
            cmd.ks_store = 1'b1;
            cmd.ks_sel   = 1'b1;
            cmd.ks_slot  = {grp_ff, 1'b1};
            cnt_in = 4'd0;
            if (grp_ff == 3'd4) begin
               // schedule done: start E(0)
               cmd.load_zero = 1'b1;
               zero_in = 1'b1;
               state_in = StRound;
            end else begin
               state_in = StKsRun;
            end
         end
         StKsRun: begin
            cmd.ks_step  = 1'b1;
            cmd.ks_const = {1'b0, grp_ff[1:0], cnt_ff[2:0]} + 6'd1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               grp_in = grp_ff + 3'd1;
               state_in = StKsPutA;
            end
         end
         StLoad: begin
            cmd.load_chain = 1'b1;
            cnt_in = 4'd0;
            state_in = StRound;
         end
         StRound: begin
            // read address runs one ahead of the registered RAM output
            cmd.round  = 1'b1;
            cmd.rk_idx = cnt_ff + 4'd1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) state_in = StFinal;
         end
         StFinal: begin
            cmd.final_xor = 1'b1;
            state_in = StDone;
         end
         StDone: begin
            if (zero_ff) begin
               cmd.save_zero = 1'b1;
               zero_in = 1'b0;
               ready_in = 1'b1;
               state_in = StLoad;
            end else if (last_ff) begin
               // hold until the tag register is free
               if (!(rsp_valid_ff && rsp_stall)) begin
                  cmd.save_tag = 1'b1;
                  cmd.clear_chain = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = StIdle;
               end
            end else begin
               cmd.save_chain = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (key_write) begin
         ready_in = 1'b0;
         cmd.clear_chain = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= '0;
         grp_ff   <= '0;
         ready_ff <= 1'b0;
         zero_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         grp_ff   <= grp_in;
         ready_ff <= ready_in;
         zero_ff  <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      full_ff <= full_in;
   end
endmodule

// ===== sv/kuznyechik_cmac_top.sv =====
// Top level of the Kuznyechik CMAC block: key registers, APB-style port, controller, datapath.
// Depends on kcm_pkg, kcm_ctrl and kcm_datapath.

// Kuznyechik CMAC with a 256-bit key. A new block is taken only once the last one is
// through: the load at the transfer, nine LSX rounds and the final key add on the shared
// round unit, and a writeback state. The tag is registered in the writeback state of the
// final block and sits in an output register until taken, so it
// does not block the input; a later final block waits in its writeback state
// while that register is still full. The first block after reset or a key write
// first runs the key schedule (two stores for the key halves, then four groups of
// eight Feistel steps and two stores), then E(0), and then loads the chain.
// Write keys only while the block is idle.
module kuznyechik_cmac_top import kcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic        req_last_block,
   input  logic        req_last_full,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_mac_tag
);
   logic [63:0] key_ff [4];
   logic        key_write, busy;
   kcm_cmd_type cmd;

   assign csr_pready = 1'b1;
   assign key_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = key_ff[csr_paddr[4:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (key_write) begin
         key_ff[csr_paddr[4:3]] <= csr_pwdata;
      end
   end

   kcm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .key_write(key_write),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_last(req_last_block), .req_full(req_last_full),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .busy(busy)
   );

   kcm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .block({req_block_high, req_block_low}),
      .tag(rsp_mac_tag)
   );

`ifndef SYNTH
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mac_tag))
      else $error("tag dropped");
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      key_write |-> !busy) else $error("key write while busy");
`endif
endmodule

// ===== test/kuznyechik_cmac_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for kuznyechik_cmac_top: drives message blocks and key writes,
// predicts each MAC tag with its own Kuznyechik/CMAC model. Depends on kcm_pkg and the RTL.
module kuznyechik_cmac_top_test;
   import kcm_pkg::*;

   localparam int unsigned ItemTarget = 1650;
   localparam int unsigned QuietItems = 150;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned SettleCycles = 100;

   typedef enum logic [1:0] {KeyWord0, KeyWord1, KeyWord2, KeyWord3} key_reg_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
      logic        full;
   } block_row_type;

   localparam logic [7:0] SUBST [256] = '{
      252,238,221, 17,207,110, 49, 22,251,196,250,218, 35,197,  4, 77,
      233,119,240,219,147, 46,153,186, 23, 54,241,187, 20,205, 95,193,
      249, 24,101, 90,226, 92,239, 33,129, 28, 60, 66,139,  1,142, 79,
        5,132,  2,174,227,106,143,160,  6, 11,237,152,127,212,211, 31,
      235, 52, 44, 81,234,200, 72,171,242, 42,104,162,253, 58,206,204,
      181,112, 14, 86,  8, 12,118, 18,191,114, 19, 71,156,183, 93,135,
       21,161,150, 41, 16,123,154,199,243,145,120,111,157,158,178,177,
       50,117, 25, 61,255, 53,138,126,109, 84,198,128,195,189, 13, 87,
      223,245, 36,169, 62,168, 67,201,215,121,214,246,124, 34,185,  3,
      224, 15,236,222,122,148,176,188,220,232, 40, 80, 78, 51, 10, 74,
      167,151, 96,115, 30,  0, 98, 68, 26,184, 56,130,100,159, 38, 65,
      173, 69, 70,146, 39, 94, 85, 47,140,163,165,125,105,213,149, 59,
        7, 88,179, 64,134,172, 29,247, 48, 55,107,228,136,217,231,137,
      225, 27,131, 73, 76, 63,248,254,141, 83,170,144,202,216,133, 97,
       32,113,103,164, 45, 43,  9, 91,203,155, 37,208,190,229,108, 82,
       89,166,116,210,230,244,180,192,209,102,175,194, 57, 75, 99,182};

   localparam logic [7:0] MIX_COEF [16] =
      '{148, 32,133, 16,194,192,  1,251,  1,192,194, 16,133, 32,148,  1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        req_last_block = 1'b0;
   logic        req_last_full = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_mac_tag;

   // predictor state
   logic [63:0]  key_reg [4];
   logic [127:0] round_keys [10];
   logic [127:0] chain_acc;
   logic [127:0] zero_cipher;
   logic         schedule_valid;
   logic [63:0]  tag_queue [$];

   int unsigned cycles = 0;
   int unsigned errors = 0;
   int unsigned blocks_sent = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;

   kuznyechik_cmac_top u_top (.*);

   always #5 clock = ~clock;

   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'hC3) : {a[6:0], 1'b0};
      end
      return p;
   endfunction

   function automatic logic [127:0] mix_bytes(input logic [127:0] v);
      logic [7:0] acc;
      for (int r = 0; r < 16; r++) begin
         acc = '0;
         for (int i = 0; i < 16; i++) acc ^= gf_times(v[127-8*i -: 8], MIX_COEF[i]);
         v = {acc, v[127:8]};
      end
      return v;
   endfunction

   function automatic logic [127:0] cipher_round(input logic [127:0] v, input logic [127:0] k);
      logic [127:0] x;
      x = v ^ k;
      for (int i = 0; i < 16; i++) x[8*i +: 8] = SUBST[x[8*i +: 8]];
      return mix_bytes(x);
   endfunction

   function automatic logic [127:0] encrypt_state(input logic [127:0] v);
      for (int r = 0; r < 9; r++) v = cipher_round(v, round_keys[r]);
      return v ^ round_keys[9];
   endfunction

   function automatic logic [127:0] shift_subkey(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   task automatic expand_schedule();
      logic [127:0] a1, a0, c, t;
      a1 = {key_reg[KeyWord0], key_reg[KeyWord1]};
      a0 = {key_reg[KeyWord2], key_reg[KeyWord3]};
      round_keys[0] = a1;
      round_keys[1] = a0;
      for (int j = 0; j < 4; j++) begin
         for (int i = 1; i <= 8; i++) begin
            c = mix_bytes(128'(8 * j + i));
            t = cipher_round(a1, c) ^ a0;
            a0 = a1;
            a1 = t;
         end
         round_keys[2*j+2] = a1;
         round_keys[2*j+3] = a0;
      end
      zero_cipher = encrypt_state('0);
      schedule_valid = 1'b1;
   endtask

   task automatic predict_tag(input block_row_type b);
      logic [127:0] v;
      if (!schedule_valid) expand_schedule();
      v = chain_acc ^ {b.hi, b.lo};
      if (b.last) v ^= b.full ? shift_subkey(zero_cipher)
                              : shift_subkey(shift_subkey(zero_cipher));
      v = encrypt_state(v);
      if (b.last) begin
         chain_acc = '0;
         tag_queue = {tag_queue, v[127:64]};
      end else begin
         chain_acc = v;
      end
   endtask

   task automatic write_key(input key_reg_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 5'(8 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      key_reg[idx] = value;
      schedule_valid = 1'b0;
      chain_acc = '0;
      @(posedge clock);
   endtask

   task automatic send_block(input block_row_type b);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_high <= b.hi;
      req_block_low  <= b.lo;
      req_last_block <= b.last;
      req_last_full  <= b.full;
      do @(posedge clock); while (req_stall);
      predict_tag(b);
      blocks_sent++;
   endtask

   // wait until every tag is back, then let a trailing non-final block finish
   task automatic drain();
      req_valid <= 1'b0;
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_message();
      int unsigned len;
      block_row_type b;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         b.hi   = rand64();
         b.lo   = rand64();
         b.last = (i == len - 1);
         b.full = 1'($urandom_range(0, 1));
         // occasionally end a message early or leave one open into the next
         if ($urandom_range(0, 19) == 0) b.last = ~b.last;
         send_block(b);
      end
   endtask

   // receiver stall bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tag_queue.size() == 0) begin
            $display("%0t: unexpected tag transfer, expected none, actual %h",
                     $time, rsp_mac_tag);
            errors++;
         end else begin
            if (rsp_mac_tag !== tag_queue[0]) begin
               $display("%0t: mac_tag mismatch, expected %h, actual %h",
                        $time, tag_queue[0], rsp_mac_tag);
               errors++;
            end
            void'(tag_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("%0t: timeout, %0d tags outstanding", $time, tag_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      block_row_type rows [$];
      block_row_type b;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      chain_acc = '0;
      zero_cipher = '0;
      schedule_valid = 1'b0;

      rows = '{
         '{64'h0, 64'h0, 1'b1, 1'b1},
         '{64'h0, 64'h0, 1'b1, 1'b0},
         '{'1, '1, 1'b1, 1'b1},
         '{'1, '1, 1'b1, 1'b0},
         '{64'h8000000000000000, 64'h0, 1'b1, 1'b0},
         '{64'h0, 64'h0000000000000001, 1'b0, 1'b1},
         '{64'h0, 64'h0, 1'b1, 1'b1},
         '{64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0, 1'b0},
         '{64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b0, 1'b1},
         '{64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b1, 1'b1},
         '{64'h1122334455667788, 64'h8000000000000000, 1'b1, 1'b0},
         '{'1, 64'h0, 1'b0, 1'b0},
         '{64'h0, '1, 1'b0, 1'b1},
         '{64'hFFFFFFFF00000000, 64'h00000000FFFFFFFF, 1'b1, 1'b0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key first, then the all-ones key
      foreach (rows[i]) send_block(rows[i]);
      drain();
      write_key(KeyWord0, '1);
      write_key(KeyWord1, '1);
      write_key(KeyWord2, '1);
      write_key(KeyWord3, '1);
      foreach (rows[i]) send_block(rows[i]);
      // leave a message open across the key change so it restarts
      b = '{64'h0123456789ABCDEF, 64'h0, 1'b0, 1'b0};
      send_block(b);
      drain();
      write_key(KeyWord2, 64'h0);
      b.last = 1'b1;
      send_block(b);
      drain();

      while (blocks_sent < ItemTarget) begin
         case ($urandom_range(0, 3))
            0: for (int i = 0; i < 4; i++) write_key(key_reg_type'(i), '0);
            1: for (int i = 0; i < 4; i++) write_key(key_reg_type'(i), '1);
            2: write_key(key_reg_type'($urandom_range(0, 3)), {$urandom, $urandom});
            default: for (int i = 0; i < 4; i++)
               write_key(key_reg_type'(i), {$urandom, $urandom});
         endcase
         repeat ($urandom_range(20, 60)) begin
            if (blocks_sent + QuietItems >= ItemTarget) quiet = 1'b1;
            if (blocks_sent < ItemTarget) send_message();
         end
         drain();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
